/* hw/rtl/phi_pkg.sv */
// shared constants and types for the pose history interpolator
package phi_pkg;
  localparam int SLOTS = 16;
  localparam int CW = $clog2(SLOTS + 1);
  localparam logic [1:0] PRED_HOLD = 2'd0;
  localparam logic [1:0] PRED_INTERP = 2'd1;
  localparam logic [1:0] PRED_EXTRAP = 2'd2;
  localparam logic [1:0] CFG_DELAY = 2'd0;
  localparam logic [1:0] CFG_LIMIT = 2'd1;
  localparam logic [1:0] CFG_GAP = 2'd2;

  typedef struct packed {
    logic [31:0] t;
    logic [31:0] px;
    logic [31:0] py;
    logic [31:0] pz;
    logic [15:0] yaw;
    logic [15:0] pitch;
    logic        vv;
    logic [31:0] vx;
    logic [31:0] vy;
    logic [31:0] vz;
  } sample_t;

  typedef struct packed {
    logic        start;
    logic        neg;
    logic [63:0] mag;
    logic [63:0] den;
  } div_req_t;
endpackage

/* hw/rtl/phi_cell.sv */
// one ring slot: holds a sample, shifts toward older slots on push, rotates on scan
module phi_cell (
  input  logic             clk,
  input  logic             load,
  input  logic             rot,
  input  phi_pkg::sample_t push_d,
  input  phi_pkg::sample_t rot_d,
  output phi_pkg::sample_t q
);
  phi_pkg::sample_t q_r;
  always_ff @(posedge clk) begin
    if (load) q_r <= push_d;
    else if (rot) q_r <= rot_d;
  end
  assign q = q_r;
endmodule

/* hw/rtl/phi_div.sv */
// rounded restoring divider on unsigned magnitudes, sign applied to the quotient, one quotient bit per cycle
module phi_div (
  input  logic               clk,
  input  logic               rst_n,
  input  phi_pkg::div_req_t  req,
  output logic               done,
  output logic signed [63:0] quo
);
  logic [63:0] rem_r, rem_nxt, q_r, q_nxt, d_r;
  logic [6:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt, neg_r, done_r, done_nxt;
  logic [64:0] tr;
  always_comb begin
    rem_nxt = rem_r; q_nxt = q_r; cnt_nxt = cnt_r; busy_nxt = busy_r; done_nxt = 1'b0;
    tr = '0;
    if (req.start) begin
      rem_nxt = '0; q_nxt = req.mag + (req.den >> 1); cnt_nxt = 7'd64; busy_nxt = 1'b1;
    end else if (busy_r) begin
      tr = {rem_r, q_r[63]};
      if (tr >= {1'b0, d_r}) begin
        tr = tr - {1'b0, d_r};
        q_nxt = {q_r[62:0], 1'b1};
      end else q_nxt = {q_r[62:0], 1'b0};
      rem_nxt = tr[63:0];
      cnt_nxt = cnt_r - 7'd1;
      if (cnt_r == 7'd1) begin busy_nxt = 1'b0; done_nxt = 1'b1; end
    end
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin busy_r <= 1'b0; done_r <= 1'b0; cnt_r <= '0; end
    else begin busy_r <= busy_nxt; done_r <= done_nxt; cnt_r <= cnt_nxt; end
    rem_r <= rem_nxt; q_r <= q_nxt;
    if (req.start) begin d_r <= req.den; neg_r <= req.neg; end
  end
  assign done = done_r;
  assign quo = neg_r ? -$signed(q_r) : $signed(q_r);
endmodule

/* hw/rtl/pose_history_interpolator_top.sv */
// top level: ring of sample cells, scan sequencer and serial rounded divider
// push: accepted while idle, no result item; pushes can follow back to back
// query: slot scan (cells rotate once through the whole ring), then up to five
// divisions, three when extrapolating and none when holding; an empty ring goes
// straight to the result without a scan
// one query at a time; result moves to an output register that holds it until taken
// synchronous active-low reset empties the ring and restores register defaults
module pose_history_interpolator_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_mode,
  input  logic [31:0] in_time_stamp,
  input  logic signed [31:0] in_pos_x,
  input  logic signed [31:0] in_pos_y,
  input  logic signed [31:0] in_pos_z,
  input  logic signed [15:0] in_yaw_in,
  input  logic signed [15:0] in_pitch_in,
  input  logic        in_has_velocity,
  input  logic signed [31:0] in_vel_x,
  input  logic signed [31:0] in_vel_y,
  input  logic signed [31:0] in_vel_z,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_found,
  output logic signed [31:0] out_out_x,
  output logic signed [31:0] out_out_y,
  output logic signed [31:0] out_out_z,
  output logic signed [15:0] out_out_yaw,
  output logic signed [15:0] out_out_pitch,
  output logic [1:0]  out_prediction,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [19:0] cfg_data
);
  localparam int N = phi_pkg::SLOTS;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001, ST_SCAN = 5'b00010, ST_DIV = 5'b00100,
    ST_WAIT = 5'b01000, ST_OUT = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic [15:0] delay_r, limit_r;
  logic [19:0] gap_max_r;
  logic [phi_pkg::CW-1:0] fill_r;
  logic [phi_pkg::CW-1:0] scnt_r, scnt_nxt;

  // cell 0 is newest, cell k is k pushes older; scan rotates oldest into view
  phi_pkg::sample_t cq [N];
  phi_pkg::sample_t cin [N];
  phi_pkg::sample_t push_s;
  logic load, rot;

  assign push_s = '{t: in_time_stamp, px: in_pos_x, py: in_pos_y, pz: in_pos_z,
                    yaw: in_yaw_in, pitch: in_pitch_in, vv: in_has_velocity,
                    vx: in_vel_x, vy: in_vel_y, vz: in_vel_z};

  genvar g;
  generate
    for (g = 0; g < N; g++) begin : g_cell
      phi_pkg::sample_t rd;
      if (g == 0) begin : g_h
        assign cin[g] = push_s;
        assign rd = cq[N-1];
      end else begin : g_b
        assign cin[g] = cq[g-1];
        assign rd = cq[g-1];
      end
      phi_cell u_cell (.clk(clk), .load(load), .rot(rot), .push_d(cin[g]),
                       .rot_d(rd), .q(cq[g]));
    end
  endgenerate

  // query context
  logic signed [33:0] at_r;
  phi_pkg::sample_t e_r, l_r, newest_r;
  logic [32:0] prev_t_r;
  logic        hit_r, hit_nxt, first_r;
  logic        prev_ok_r;
  logic [1:0]  pred_r;
  logic [2:0]  op_r, op_nxt;
  logic signed [33:0] num_r, gap_r;
  logic signed [31:0] res_x_r, res_y_r, res_z_r;
  logic signed [15:0] res_yaw_r, res_pitch_r;
  logic        found_r, ov_r;

  // output register, frees the query context while a result waits
  logic        o_found_r;
  logic signed [31:0] o_x_r, o_y_r, o_z_r;
  logic signed [15:0] o_yaw_r, o_pitch_r;
  logic [1:0]  o_pred_r;

  phi_pkg::div_req_t dreq;
  logic               ddone;
  logic signed [63:0] dquo;
  phi_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .done(ddone), .quo(dquo));

  assign in_ready = (state_r == ST_IDLE);
  assign out_valid = ov_r;
  assign load = in_valid && in_ready && !in_mode;
  assign rot  = (state_r == ST_SCAN);

  // scan: cq[N-1] rotates through as oldest..newest, since rotation visits
  // slots in order; a ring not full first spends N-fill rotations on blanks
  logic signed [33:0] tcur;
  logic               valid_slot;
  assign tcur = $signed({2'b00, cq[N-1].t});
  assign valid_slot = (scnt_r >= phi_pkg::CW'(N) - fill_r);

  // operand selection for divisions; the multiplier is difference times step count
  logic signed [33:0] a_e, a_l;
  logic signed [55:0] prod_n;
  logic signed [63:0] prod;
  logic signed [33:0] nvx;
  always_comb begin
    a_e = '0; a_l = '0;
    unique case (op_r)
      3'd0: begin a_e = 34'($signed(e_r.px)); a_l = 34'($signed(l_r.px)); end
      3'd1: begin a_e = 34'($signed(e_r.py)); a_l = 34'($signed(l_r.py)); end
      3'd2: begin a_e = 34'($signed(e_r.pz)); a_l = 34'($signed(l_r.pz)); end
      3'd3: begin a_e = 34'($signed(e_r.yaw)); a_l = 34'($signed(l_r.yaw)); end
      default: begin a_e = 34'($signed(e_r.pitch)); a_l = 34'($signed(l_r.pitch)); end
    endcase
    nvx = a_l - a_e;
    // step count is below max_gap or extrap_limit, so it fits in 21 bits
    prod_n = nvx * $signed({1'b0, num_r[20:0]});
    prod = 64'(prod_n);
  end

  // interpolated value: earlier sample plus rounded share of the difference
  logic signed [34:0] acc;
  always_comb begin
    acc = 35'(a_e) + 35'(dquo);
  end

  always_comb begin
    state_nxt = state_r; scnt_nxt = scnt_r; op_nxt = op_r; hit_nxt = hit_r;
    dreq = '{start: 1'b0, neg: prod < 0, mag: prod < 0 ? 64'(-prod) : 64'(prod),
             den: 64'(gap_r)};
    unique case (state_r)
      ST_IDLE: if (in_valid && in_mode) begin
        state_nxt = (fill_r == '0) ? ST_OUT : ST_SCAN;
        scnt_nxt = '0; hit_nxt = 1'b0;
      end
      ST_SCAN: begin
        scnt_nxt = scnt_r + 1'b1;
        if (scnt_r == phi_pkg::CW'(N - 1)) state_nxt = ST_DIV;
      end
      ST_DIV: begin
        // three position divisions to extrapolate, five with angles to interpolate
        if (pred_r == phi_pkg::PRED_HOLD || gap_r == 0 ||
            (pred_r == phi_pkg::PRED_EXTRAP && op_r > 3'd2) || op_r > 3'd4)
          state_nxt = ST_OUT;
        else begin dreq.start = 1'b1; state_nxt = ST_WAIT; end
      end
      ST_WAIT: if (ddone) begin
        op_nxt = op_r + 3'd1;
        state_nxt = ST_DIV;
      end
      ST_OUT: if (!ov_r || out_ready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // newest position plus rounded displacement, saturated
  function automatic logic [31:0] sat_add(input logic [31:0] p);
    logic signed [64:0] s;
    s = 65'($signed(p)) + 65'(dquo);
    if (s > 65'sd2147483647) return 32'h7fffffff;
    else if (s < -65'sd2147483648) return 32'h80000000;
    else return s[31:0];
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE; fill_r <= '0; ov_r <= 1'b0;
      delay_r <= 16'd1600; limit_r <= 16'd4000; gap_max_r <= 20'd16000;
      scnt_r <= '0; op_r <= '0; hit_r <= 1'b0;
    end else begin
      state_r <= state_nxt; scnt_r <= scnt_nxt; op_r <= op_nxt; hit_r <= hit_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          phi_pkg::CFG_DELAY: delay_r <= cfg_data[15:0];
          phi_pkg::CFG_LIMIT: limit_r <= cfg_data[15:0];
          phi_pkg::CFG_GAP:   gap_max_r <= cfg_data;
          default: ;
        endcase
      end
      if (load && fill_r != phi_pkg::CW'(N)) fill_r <= fill_r + 1'b1;
      if (out_valid && out_ready) ov_r <= 1'b0;
      if (state_r == ST_OUT && state_nxt == ST_IDLE) ov_r <= 1'b1;
      if (state_r == ST_IDLE && state_nxt == ST_SCAN) op_r <= '0;
    end
    // payload
    if (state_r == ST_IDLE && in_valid && in_mode) begin
      at_r <= $signed({2'b00, in_time_stamp}) - $signed({18'd0, delay_r});
      newest_r <= cq[0];
      first_r <= 1'b1; prev_ok_r <= 1'b0; pred_r <= phi_pkg::PRED_HOLD;
      found_r <= (fill_r != '0);
      res_x_r <= (fill_r != '0) ? cq[0].px : '0;
      res_y_r <= (fill_r != '0) ? cq[0].py : '0;
      res_z_r <= (fill_r != '0) ? cq[0].pz : '0;
      res_yaw_r <= (fill_r != '0) ? cq[0].yaw : '0;
      res_pitch_r <= (fill_r != '0) ? cq[0].pitch : '0;
      gap_r <= '0;
    end
    if (state_r == ST_SCAN && valid_slot) begin
      prev_t_r <= {1'b0, cq[N-1].t};
      if (first_r) begin
        first_r <= 1'b0;
        // oldest must be at or before the moment, and moment at or before newest
        prev_ok_r <= (tcur <= at_r) && (at_r <= $signed({2'b00, newest_r.t})) &&
                     (fill_r >= phi_pkg::CW'(2));
        e_r <= cq[N-1];
      end else if (prev_ok_r && !hit_r) begin
        if (tcur >= at_r) begin
          hit_r <= 1'b1;
          l_r <= cq[N-1];
          if (tcur - $signed({1'b0, prev_t_r}) > 0 &&
              tcur - $signed({1'b0, prev_t_r}) < $signed({14'd0, gap_max_r})) begin
            pred_r <= phi_pkg::PRED_INTERP;
            gap_r <= tcur - $signed({1'b0, prev_t_r});
            num_r <= (tcur - $signed({1'b0, prev_t_r}) > 34'sd16) ?
                     at_r - $signed({1'b0, prev_t_r}) : tcur - $signed({1'b0, prev_t_r});
          end
        end else e_r <= cq[N-1];
      end
    end
    // extrapolation setup in the scan step that visits the newest slot; after
    // N-1 rotations the sample one push older than newest sits in cell 0
    if (state_r == ST_SCAN && scnt_r == phi_pkg::CW'(N - 1) &&
        at_r > $signed({2'b00, newest_r.t}) &&
        at_r - $signed({2'b00, newest_r.t}) < $signed({18'd0, limit_r})) begin
      pred_r <= phi_pkg::PRED_EXTRAP;
      num_r <= at_r - $signed({2'b00, newest_r.t});
      if (newest_r.vv) begin
        e_r <= '{t: '0, px: '0, py: '0, pz: '0, yaw: '0, pitch: '0, vv: 1'b0,
                 vx: '0, vy: '0, vz: '0};
        l_r <= '{t: newest_r.t, px: newest_r.vx, py: newest_r.vy, pz: newest_r.vz,
                 yaw: '0, pitch: '0, vv: 1'b1, vx: '0, vy: '0, vz: '0};
        gap_r <= 34'sd16000;
      end else if (fill_r >= phi_pkg::CW'(2) &&
                   $signed({2'b00, newest_r.t}) - $signed({1'b0, prev_t_r}) > 0) begin
        e_r <= cq[0];
        l_r <= newest_r;
        gap_r <= $signed({2'b00, newest_r.t}) - $signed({1'b0, prev_t_r});
      end else gap_r <= '0;
    end
    if (state_r == ST_WAIT && ddone) begin
      unique case (op_r)
        3'd0: res_x_r <= pred_r == phi_pkg::PRED_INTERP ? acc[31:0] : sat_add(newest_r.px);
        3'd1: res_y_r <= pred_r == phi_pkg::PRED_INTERP ? acc[31:0] : sat_add(newest_r.py);
        3'd2: res_z_r <= pred_r == phi_pkg::PRED_INTERP ? acc[31:0] : sat_add(newest_r.pz);
        3'd3: res_yaw_r <= acc[15:0];
        default: res_pitch_r <= acc[15:0];
      endcase
    end
    // finished result moves to the output register
    if (state_r == ST_OUT && (!ov_r || out_ready)) begin
      o_found_r <= found_r;
      o_x_r <= res_x_r; o_y_r <= res_y_r; o_z_r <= res_z_r;
      o_yaw_r <= res_yaw_r; o_pitch_r <= res_pitch_r;
      o_pred_r <= pred_r;
    end
  end

  assign out_found = o_found_r;
  assign out_out_x = o_x_r;
  assign out_out_y = o_y_r;
  assign out_out_z = o_z_r;
  assign out_out_yaw = o_yaw_r;
  assign out_out_pitch = o_pitch_r;
  assign out_prediction = o_pred_r;

  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> state_r == ST_IDLE) else $error("ready outside idle");
  a_fill_max: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= phi_pkg::CW'(N)) else $error("fill count overflow");
  a_empty_nf: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_prediction == phi_pkg::PRED_HOLD)
    else $error("empty ring with prediction");
endmodule
